[rtl/onewire_temp_scratchpad_decode_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the scratchpad temperature decoder
// Concurrent checks on clk, disabled while rst_n is low; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ONEWIRE_TEMP_SCRATCHPAD_DECODE_MACROS_SVH
`define ONEWIRE_TEMP_SCRATCHPAD_DECODE_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define OSP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");
// next-cycle implication
`define OSP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");
`else
`define OSP_ASSERT_IMP(lbl, ante, cons)
`define OSP_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[rtl/osp_pkg.sv]
// ----------------------------------------------------------------------------
// osp_pkg
// Shared types, constants and the CRC-8 byte update for the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package osp_pkg;

  // family code that selects the old 9-bit decoding
  localparam logic [7:0] FAMILY_OLD      = 8'h10;
  localparam logic [7:0] FAMILY_RESET    = 8'h28;
  // count-per-degree value that enables count-remain refinement
  localparam logic [7:0] COUNT_PER_C_STD = 8'h10;
  localparam logic [15:0] REMAIN_BIAS    = 16'd12;
  localparam logic [15:0] OLD_INT_MASK   = 16'hFFF0;

  // Dallas/Maxim CRC-8, reflected
  localparam logic [7:0] CRC_POLY = 8'h8C;

  // bytes 0..7 feed the CRC; the ninth carries the CRC
  localparam int unsigned SCRATCH_LEN = 8;
  localparam int unsigned COUNT_W     = $clog2(SCRATCH_LEN + 1);

  // resolution field, byte 4 bits 6:5
  localparam logic [1:0] RES_9BIT  = 2'b00;
  localparam logic [1:0] RES_10BIT = 2'b01;
  localparam logic [1:0] RES_11BIT = 2'b10;
  localparam logic [1:0] RES_12BIT = 2'b11;

  // register index (paddr[2])
  localparam logic REG_FAMILY = 1'b0;

  localparam int unsigned OSP_QUEUE_DEPTH = 2;

  // finished frame handed from front to back
  typedef struct packed {
    logic       crc_bad;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b4;
    logic [7:0] b6;
    logic [7:0] b7;
  } frame_t;

  // occupancy flags of the frame queue
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/onewire_temp_scratchpad_decode.sv]
// The decoder takes one scratchpad byte per cycle while in_stall is low and
// gives one result per nine-byte frame: status 0 with the new reading in
// signed 1/16 degree C, or status 1 with the last good reading when the
// CRC-8 does not match. The front end counts bytes and updates the CRC as
// each byte is taken; a queue of QUEUE_DEPTH frame records lets it keep
// taking bytes while a result waits on out_stall, and in_stall rises only
// when that queue is full. family_code is written over the APB port at byte
// address 0; the user must write it only while no frame is in flight, and the block does not enforce it.
// ----------------------------------------------------------------------------
// onewire_temp_scratchpad_decode
// 1-Wire temperature scratchpad CRC check and reading decode, top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "onewire_temp_scratchpad_decode_macros.svh"

module onewire_temp_scratchpad_decode
  import osp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = OSP_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready,
  // input items
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_frame_start,
  input  wire logic [7:0]  in_data_byte,
  // result items
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_status,
  output logic signed [15:0] out_temperature
);

  logic [7:0] family_code_r;
  logic       cfg_wr;
  logic       q_push, q_pop;
  frame_t     q_wdata, q_rdata;
  q_status_t  q_status;

  // register write and readback
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    if (cfg_paddr[2] == REG_FAMILY) begin
      cfg_prdata = {24'h000000, family_code_r};
    end else begin
      cfg_prdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      family_code_r <= FAMILY_RESET;
    end else if (cfg_wr && cfg_paddr[2] == REG_FAMILY) begin
      family_code_r <= cfg_pwdata[7:0];
    end
  end

  osp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_frame_start (in_frame_start),
    .in_data_byte   (in_data_byte),
    .q_status       (q_status),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  osp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .status (q_status)
  );

  osp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .family_code     (family_code_r),
    .q_status        (q_status),
    .q_rdata         (q_rdata),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_temperature (out_temperature)
  );

  // queue never overflows or underflows; a good frame yields a good result
  `OSP_ASSERT_IMP(a_no_overflow, q_push, !q_status.full)
  `OSP_ASSERT_IMP(a_no_underflow, q_pop, !q_status.empty)
  `OSP_ASSERT_NXT(a_good_result, q_pop && !q_rdata.crc_bad, out_valid && !out_status)

endmodule

`default_nettype wire

[rtl/osp_front.sv]
// ----------------------------------------------------------------------------
// osp_front
// Counts scratchpad bytes, runs the CRC, keeps the bytes the decode needs
// and pushes one frame record into the queue on the ninth byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module osp_front
  import osp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_frame_start,
  input  wire logic [7:0] in_data_byte,
  input  wire q_status_t  q_status,
  output logic            q_push,
  output frame_t          q_wdata
);

  logic [COUNT_W-1:0] cnt_r, cnt_nxt, cnt_eff;
  logic [7:0]         crc_r, crc_nxt, crc_eff;
  logic [7:0]         b0_r, b1_r, b4_r, b6_r, b7_r;
  logic               accept;
  logic               last_byte;

  // restart count and CRC when a frame start is flagged
  always_comb begin
    cnt_eff   = in_frame_start ? '0 : cnt_r;
    crc_eff   = in_frame_start ? '0 : crc_r;
    accept    = in_valid & ~q_status.full;
    last_byte = (cnt_eff == COUNT_W'(SCRATCH_LEN));
    cnt_nxt   = cnt_r;
    crc_nxt   = crc_r;
    if (accept) begin
      if (last_byte) begin
        cnt_nxt = '0;
        crc_nxt = '0;
      end else begin
        cnt_nxt = cnt_eff + COUNT_W'(1);
        crc_nxt = crc_byte(crc_eff, in_data_byte);
      end
    end
  end

  assign in_stall = q_status.full;
  assign q_push   = accept & last_byte;

  always_comb begin
    q_wdata.crc_bad = (crc_eff != in_data_byte);
    q_wdata.b0      = b0_r;
    q_wdata.b1      = b1_r;
    q_wdata.b4      = b4_r;
    q_wdata.b6      = b6_r;
    q_wdata.b7      = b7_r;
  end

  // advance count and CRC
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      crc_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      crc_r <= crc_nxt;
    end
  end

  // store the bytes the decode reads
  always_ff @(posedge clk) begin
    if (accept && !last_byte) begin
      case (cnt_eff[2:0])
        3'd0:    b0_r <= in_data_byte;
        3'd1:    b1_r <= in_data_byte;
        3'd4:    b4_r <= in_data_byte;
        3'd6:    b6_r <= in_data_byte;
        3'd7:    b7_r <= in_data_byte;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/osp_queue.sv]
// ----------------------------------------------------------------------------
// osp_queue
// Small FIFO of finished frame records between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module osp_queue
  import osp_pkg::*;
#(
  parameter int unsigned DEPTH = OSP_QUEUE_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire frame_t    wdata,
  input  wire logic      pop,
  output frame_t         rdata,
  output q_status_t      status
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  frame_t             mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign status.full  = (cnt_r == CNT_W'(DEPTH));
  assign status.empty = (cnt_r == '0);
  assign rdata        = mem_r[rd_ptr_r];

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  // write the entry
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule

`default_nettype wire

[rtl/osp_back.sv]
// ----------------------------------------------------------------------------
// osp_back
// Decodes a queued frame to sixteenths of a degree, keeps the last good
// reading and drives the registered result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module osp_back
  import osp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [7:0]  family_code,
  input  wire q_status_t   q_status,
  input  wire frame_t      q_rdata,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_status,
  output logic signed [15:0] out_temperature
);

  logic        out_valid_r, out_valid_nxt;
  logic        status_r;
  logic [15:0] temp_r;
  logic [15:0] last_good_r;
  logic [15:0] raw, old_raw, decoded;

  // decode the reading of the head frame
  always_comb begin
    raw     = {q_rdata.b1, q_rdata.b0};
    old_raw = {raw[12:0], 3'b000};
    if (family_code == FAMILY_OLD) begin
      if (q_rdata.b7 == COUNT_PER_C_STD) begin
        decoded = (old_raw & OLD_INT_MASK) + REMAIN_BIAS - {8'h00, q_rdata.b6};
      end else begin
        decoded = old_raw;
      end
    end else begin
      unique case (q_rdata.b4[6:5])
        RES_9BIT:  decoded = {raw[15:3], 3'b000};
        RES_10BIT: decoded = {raw[15:2], 2'b00};
        RES_11BIT: decoded = {raw[15:1], 1'b0};
        RES_12BIT: decoded = raw;
      endcase
    end
  end

  // take the head when the output register is free or drains
  assign q_pop = ~q_status.empty & (~out_valid_r | ~out_stall);

  always_comb begin
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r & out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      last_good_r <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop && !q_rdata.crc_bad) last_good_r <= decoded;
    end
  end

  // load the result; hold the last good reading on a CRC mismatch
  always_ff @(posedge clk) begin
    if (q_pop) begin
      status_r <= q_rdata.crc_bad;
      temp_r   <= q_rdata.crc_bad ? last_good_r : decoded;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_temperature = signed'(temp_r);

endmodule

`default_nettype wire
